/* hw/rtl/rtc_pkg.sv */
// Shared types, constants and helper functions for the radix text codec.
// Used by rtc_ctrl, rtc_dp and radix_text_codec; depends on nothing else.
package rtc_pkg;

	// Code table geometry and fixed character codes
	localparam int unsigned TABLE_ENTRIES = 95;
	localparam int unsigned TBL_AW        = 7;
	localparam int unsigned CODE_W        = 16;
	localparam int unsigned DIV_CW        = 4;
	localparam int unsigned NDIG_W        = 5;
	localparam logic [7:0]  FIRST_CHAR    = 8'd32;
	localparam logic [7:0]  LAST_CHAR     = 8'd126;
	localparam logic [7:0]  SPACE_CHAR    = 8'd32;
	localparam logic [7:0]  NO_MATCH_CHAR = 8'd254;
	localparam logic [7:0]  CHAR_0        = 8'd48;
	localparam logic [7:0]  CHAR_UA       = 8'd65;
	localparam logic [7:0]  CHAR_LA       = 8'd97;

	// Input item kinds (carried on tuser)
	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_RESTORE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_RADIX     = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC_LOOK,
		ST_ENC_DIV,
		ST_ENC_EMIT,
		ST_DEC_SCAN,
		ST_DEC_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic enc_load;
		logic div_step;
		logic emit_digit;
		logic emit_space;
		logic scan_step;
		logic emit_dec;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic take_enc;
		logic take_dec_close;
		logic code_zero;
		logic div_last;
		logic quot_zero;
		logic dig_empty;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

	// Map a digit value 0..61 to its character
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d < 6'd10) begin
			c = CHAR_0 + 8'(d);
		end else if (d < 6'd36) begin
			c = CHAR_UA + 8'(d - 6'd10);
		end else begin
			c = CHAR_LA + 8'(d - 6'd36);
		end
		return c;
	endfunction

	// Digit value of a character in base r; non-digits count as zero
	function automatic logic [5:0] digit_val(input logic [7:0] c, input logic [5:0] r);
		logic [5:0] d;
		d = 6'd0;
		if (c >= CHAR_0 && c <= 8'd57) begin
			d = 6'(c - CHAR_0);
		end else if (c >= CHAR_UA && c <= 8'd90) begin
			d = 6'(c - CHAR_UA) + 6'd10;
		end else if (c >= CHAR_LA && c <= 8'd122) begin
			d = 6'(c - CHAR_LA) + 6'd36;
		end
		return (d < r) ? d : 6'd0;
	endfunction

endpackage

/* hw/rtl/rtc_ctrl.sv */
// Controller state machine of the radix text codec.
// Depends on rtc_pkg; drives rtc_dp through ctrl_cmd_t and reads dp_stat_t.
module rtc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rtc_pkg::dp_stat_t stat,
	output logic              in_ready,
	output rtc_pkg::ctrl_cmd_t cmd
);
	import rtc_pkg::*;

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.take_enc) begin
						state_nxt = ST_ENC_LOOK;
					end else if (stat.take_dec_close) begin
						state_nxt = ST_DEC_SCAN;
					end
				end
			end
			ST_ENC_LOOK: begin
				state_nxt = stat.code_zero ? ST_ENC_EMIT : ST_ENC_DIV;
			end
			ST_ENC_DIV: begin
				if (stat.div_last && stat.quot_zero) begin
					state_nxt = ST_ENC_EMIT;
				end
			end
			ST_ENC_EMIT: begin
				if (stat.out_free && stat.dig_empty) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DEC_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = ST_DEC_EMIT;
				end
			end
			ST_DEC_EMIT: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.enc_load   = (state_q == ST_ENC_LOOK);
		cmd.div_step   = (state_q == ST_ENC_DIV);
		cmd.emit_digit = (state_q == ST_ENC_EMIT) && stat.out_free && !stat.dig_empty;
		cmd.emit_space = (state_q == ST_ENC_EMIT) && stat.out_free && stat.dig_empty;
		cmd.scan_step  = (state_q == ST_DEC_SCAN);
		cmd.emit_dec   = (state_q == ST_DEC_EMIT) && stat.out_free;
	end

endmodule

/* hw/rtl/rtc_dp.sv */
// Datapath of the radix text codec: config registers, code table memory,
// bit-serial divider, digit buffer, token accumulator, table scan, output register.
// Depends on rtc_pkg; commanded by rtc_ctrl.
module rtc_dp #(
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned MAX_RADIX   = 62
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data,
	// input item fields
	input  logic [1:0]         in_cmd,
	input  logic [7:0]         in_char,
	input  logic [6:0]         in_index,
	input  logic [15:0]        in_value,
	input  logic               in_eom,
	// control
	input  rtc_pkg::ctrl_cmd_t cmd,
	output rtc_pkg::dp_stat_t  stat,
	// result
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         out_char,
	output logic               out_last,
	output logic               out_nf
);
	import rtc_pkg::*;

	localparam int unsigned CMP_W = (VALUE_WIDTH > CODE_W) ? VALUE_WIDTH : CODE_W;
	localparam logic [5:0]  RMAX  = 6'(MAX_RADIX);

	logic                   dir_q;
	logic [5:0]             radix_q;
	logic [5:0]             r_act;
	logic [CODE_W-1:0]      mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [CODE_W-1:0]      rd_data_q;
	logic                   rd_vld_q;
	logic [TBL_AW-1:0]      rd_addr_q;
	logic                   rd_en;
	logic [TBL_AW-1:0]      rd_addr;
	logic [CODE_W-1:0]      entry;
	logic [CODE_W-1:0]      dvd_q;
	logic [5:0]             rem_q;
	logic [DIV_CW-1:0]      bit_q;
	logic [6:0]             rem_sh;
	logic                   ge;
	logic [5:0]             rem_nxt;
	logic [CODE_W-1:0]      dvd_nxt;
	logic [5:0]             dig_buf [CODE_W];
	logic [NDIG_W-1:0]      ndig_q;
	logic [VALUE_WIDTH-1:0] token_q;
	logic [VALUE_WIDTH+5:0] prod;
	logic [TBL_AW-1:0]      scan_q;
	logic                   cmp_pend_q;
	logic                   issue;
	logic                   match_q;
	logic [TBL_AW-1:0]      hit_q;
	logic                   is_data;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;
	logic                   out_nf_q;

	// Clamp the radix into its legal range
	always_comb begin
		if (radix_q < 6'd2) begin
			r_act = 6'd2;
		end else if (radix_q > RMAX) begin
			r_act = RMAX;
		end else begin
			r_act = radix_q;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 1'b0;
			radix_q <= 6'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DIRECTION: dir_q   <= cfg_data[0];
				CFG_RADIX:     radix_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Classify the offered item
	assign is_data = (in_cmd == CMD_DATA);
	assign stat.take_enc = is_data && !dir_q && in_char >= FIRST_CHAR && in_char <= LAST_CHAR;
	assign stat.take_dec_close = is_data && dir_q && (in_char == SPACE_CHAR || in_eom);

	// Table read port: encode lookup at accept, otherwise the scan
	assign issue   = cmd.scan_step && (scan_q < TBL_AW'(TABLE_ENTRIES));
	assign rd_en   = (cmd.accept && stat.take_enc) || issue;
	assign rd_addr = cmd.accept ? TBL_AW'(in_char - FIRST_CHAR) : scan_q;

	// Table memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && in_cmd == CMD_WRITE && in_index < TBL_AW'(TABLE_ENTRIES)) begin
			mem[in_index] <= in_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Valid bits: unwritten entries read as their default code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.accept) begin
			if (in_cmd == CMD_RESTORE) begin
				vld_q <= '0;
			end else if (in_cmd == CMD_WRITE && in_index < TBL_AW'(TABLE_ENTRIES)) begin
				vld_q[in_index] <= 1'b1;
			end
		end
	end

	assign entry = rd_vld_q ? rd_data_q : (CODE_W'(rd_addr_q) + CODE_W'(FIRST_CHAR));
	assign stat.code_zero = (entry == '0);

	// Restoring divide step, one quotient bit per cycle
	assign rem_sh  = {rem_q, dvd_q[CODE_W-1]};
	assign ge      = (rem_sh >= {1'b0, r_act});
	assign rem_nxt = ge ? 6'(rem_sh - {1'b0, r_act}) : rem_sh[5:0];
	assign dvd_nxt = {dvd_q[CODE_W-2:0], ge};

	assign stat.div_last  = (bit_q == '0);
	assign stat.quot_zero = (dvd_nxt == '0);
	assign stat.dig_empty = (ndig_q == '0);

	// Divider and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
			bit_q  <= '0;
		end else if (cmd.enc_load) begin
			ndig_q <= '0;
			bit_q  <= DIV_CW'(CODE_W - 1);
		end else if (cmd.div_step) begin
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0) begin
				ndig_q <= ndig_q + 1'b1;
			end
		end else if (cmd.emit_digit) begin
			ndig_q <= ndig_q - 1'b1;
		end
	end

	// Dividend, remainder and digit buffer
	always_ff @(posedge clk) begin
		if (cmd.enc_load) begin
			dvd_q <= entry;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_nxt;
			rem_q <= (bit_q == '0) ? 6'd0 : rem_nxt;
			if (bit_q == '0) begin
				dig_buf[ndig_q[DIV_CW-1:0]] <= rem_nxt;
			end
		end
	end

	// Token accumulator: shift in one digit per character
	assign prod = (VALUE_WIDTH+6)'(token_q) * (VALUE_WIDTH+6)'(r_act)
		+ (VALUE_WIDTH+6)'(digit_val(in_char, r_act));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else if (cmd.accept && is_data && dir_q && in_char != SPACE_CHAR) begin
			token_q <= prod[VALUE_WIDTH-1:0];
		end else if (cmd.emit_dec) begin
			token_q <= '0;
		end
	end

	// Reverse lookup: scan all entries, the highest match wins
	assign stat.scan_done = (scan_q == TBL_AW'(TABLE_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_pend_q <= 1'b0;
			match_q    <= 1'b0;
			hit_q      <= '0;
		end else if (cmd.accept) begin
			scan_q     <= '0;
			cmp_pend_q <= 1'b0;
			match_q    <= 1'b0;
		end else begin
			cmp_pend_q <= issue;
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmp_pend_q && CMP_W'(entry) == CMP_W'(token_q)) begin
				match_q <= 1'b1;
				hit_q   <= rd_addr_q;
			end
		end
	end

	// Output register
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_digit || cmd.emit_space || cmd.emit_dec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_digit) begin
			out_char_q <= digit_char(dig_buf[DIV_CW'(ndig_q - 1'b1)]);
			out_last_q <= 1'b0;
			out_nf_q   <= 1'b0;
		end else if (cmd.emit_space) begin
			out_char_q <= SPACE_CHAR;
			out_last_q <= 1'b1;
			out_nf_q   <= 1'b0;
		end else if (cmd.emit_dec) begin
			out_char_q <= match_q ? (8'(hit_q) + FIRST_CHAR) : NO_MATCH_CHAR;
			out_last_q <= 1'b1;
			out_nf_q   <= !match_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_nf    = out_nf_q;

	// Checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit || cmd.emit_space || cmd.emit_dec) |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending one");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < r_act))
		else $error("divider remainder out of range");
	a_ndig_max: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= NDIG_W'(CODE_W))
		else $error("digit buffer overflow");
	a_scan_max: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= TBL_AW'(TABLE_ENTRIES))
		else $error("scan address past table");
	a_scan_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_dec |-> (!cmp_pend_q && stat.scan_done))
		else $error("decode result before scan finished");

endmodule

/* hw/rtl/radix_text_codec.sv */
// Top level of the radix text codec: ties controller and datapath to the ports.
// Depends on rtc_pkg, rtc_ctrl and rtc_dp.
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one character or table command
//  m_axis    out        m_axis_tvalid/m_axis_tready  one output character
//  cfg       in         cfg_valid/cfg_ready          register index and value
//
// Encode: accept, lookup, then a bit-serial divide per digit, then the emit of each
// digit and the space; a code of zero goes from the lookup straight to the space.
// Decode close: the block scans all 95 table entries over the single read port
// before it emits the result.
// Table writes, restores and non-closing decode characters are taken from idle.
// Reset needs no clearing pass: per-entry valid bits restore the default table.
// A stalled output holds its result; the next item is taken while it waits.
module radix_text_codec #(
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned MAX_RADIX   = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // char_code[7:0], entry_index[14:8], entry_value[30:15]
	input  logic        s_axis_tlast,  // end_of_message
	input  logic [1:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_char[7:0]
	output logic        m_axis_tlast,  // run_last
	output logic        m_axis_tuser,  // not_found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);
	import rtc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Config writes are always taken
	assign cfg_ready = 1'b1;

	rtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	rtc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_RADIX   (MAX_RADIX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_cmd    (s_axis_tuser),
		.in_char   (s_axis_tdata[7:0]),
		.in_index  (s_axis_tdata[14:8]),
		.in_value  (s_axis_tdata[30:15]),
		.in_eom    (s_axis_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_nf    (m_axis_tuser)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for radix_text_codec: drives character and table
// requests, predicts every output character in a behavioral copy of the codec
// and checks each output request field by field. Depends on rtc_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtc_pkg::*;

	localparam logic [1:0]  CMD_UNUSED    = 2'd3;
	localparam int unsigned MAX_BASE      = 62;
	localparam int unsigned LIMIT_CYCLES  = 1500000;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS  = 370;
	localparam int unsigned PHASE_ITEMS   = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       nf;
	} out_char_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic [1:0]  s_axis_tuser  = CMD_DATA;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = CFG_DIRECTION;
	logic [5:0]  cfg_data      = '0;

	// Predictor state: code table, open decode token and register copies
	logic [15:0] code_tbl [TABLE_ENTRIES];
	logic [15:0] token_acc = '0;
	logic        dir_mode  = 1'b0;
	logic [5:0]  radix_reg = 6'd16;
	out_char_t   expected_chars [$];

	int unsigned errors     = 0;
	int unsigned items_sent = 0;
	int unsigned cycles     = 0;
	int unsigned rx_hold    = 0;
	bit          tx_idle    = 1'b1;
	bit          rx_idle    = 1'b1;

	radix_text_codec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned eff_radix();
		if (radix_reg < 2)
			return 2;
		if (radix_reg > MAX_BASE)
			return MAX_BASE;
		return radix_reg;
	endfunction

	function automatic logic [7:0] char_of_digit(input int unsigned d);
		if (d < 10)
			return 8'(CHAR_0 + d);
		if (d < 36)
			return 8'(CHAR_UA + d - 10);
		return 8'(CHAR_LA + d - 36);
	endfunction

	// Digit value in base r; anything that is not a digit of r counts as zero
	function automatic int unsigned value_of_char(input logic [7:0] c, input int unsigned r);
		int unsigned d;
		d = r;
		if (c >= CHAR_0 && c < CHAR_0 + 10)
			d = c - CHAR_0;
		else if (c >= CHAR_UA && c < CHAR_UA + 26)
			d = c - CHAR_UA + 10;
		else if (c >= CHAR_LA && c < CHAR_LA + 26)
			d = c - CHAR_LA + 36;
		return (d < r) ? d : 0;
	endfunction

	function automatic out_char_t out_rec(input logic [7:0] c, input logic l, input logic n);
		out_char_t o;
		o.ch   = c;
		o.last = l;
		o.nf   = n;
		return o;
	endfunction

	task automatic restore_table();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			code_tbl[i] = 16'(i + FIRST_CHAR);
	endtask

	// Apply one accepted request to the predictor and queue its output characters
	task automatic predict_output_chars(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [6:0] idx, input logic [15:0] val, input logic eom);
		int unsigned r, code, n;
		int          hit;
		logic [5:0]  digs [16];
		r = eff_radix();
		case (cmd)
			CMD_WRITE: begin
				if (idx < TABLE_ENTRIES)
					code_tbl[idx] = val;
			end
			CMD_RESTORE: begin
				restore_table();
			end
			CMD_DATA: begin
				if (!dir_mode) begin
					if (ch >= FIRST_CHAR && ch <= LAST_CHAR) begin
						code = code_tbl[ch - FIRST_CHAR];
						n = 0;
						while (code != 0 && n < 16) begin
							digs[n] = 6'(code % r);
							code = code / r;
							n++;
						end
						while (n > 0) begin
							n--;
							expected_chars.push_back(out_rec(char_of_digit(digs[n]), 1'b0, 1'b0));
						end
						expected_chars.push_back(out_rec(SPACE_CHAR, 1'b1, 1'b0));
					end
				end else begin
					if (ch != SPACE_CHAR)
						token_acc = 16'(token_acc * r + value_of_char(ch, r));
					if (ch == SPACE_CHAR || eom) begin
						// highest matching entry wins
						hit = -1;
						for (int i = 0; i < TABLE_ENTRIES; i++)
							if (code_tbl[i] == token_acc)
								hit = i;
						if (hit < 0)
							expected_chars.push_back(out_rec(NO_MATCH_CHAR, 1'b1, 1'b1));
						else
							expected_chars.push_back(out_rec(8'(hit + FIRST_CHAR), 1'b1, 1'b0));
						token_acc = '0;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offer one input request, after a random gap while tx_idle is set, and wait for its acceptance
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [6:0] idx, input logic [15:0] val, input logic eom);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, val, idx, ch};
		s_axis_tlast  <= eom;
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_output_chars(cmd, ch, idx, val, eom);
		items_sent++;
	endtask

	task automatic send_data(input logic [7:0] ch, input logic eom);
		send_item(CMD_DATA, ch, 7'($urandom), 16'($urandom), eom);
	endtask

	task automatic send_write(input logic [6:0] idx, input logic [15:0] val);
		send_item(CMD_WRITE, 8'($urandom), idx, val, 1'($urandom));
	endtask

	task automatic send_other(input logic [1:0] cmd);
		send_item(cmd, 8'($urandom), 7'($urandom), 16'($urandom), 1'($urandom));
	endtask

	// Send the digits of a character's current code as one decode token
	task automatic send_token(input logic [7:0] target);
		int unsigned r, code, n;
		logic [5:0]  digs [16];
		logic        by_space;
		r = eff_radix();
		code = code_tbl[target - FIRST_CHAR];
		n = 0;
		while (code != 0 && n < 16) begin
			digs[n] = 6'(code % r);
			code = code / r;
			n++;
		end
		by_space = (n == 0) || ($urandom_range(0, 1) == 1);
		if ($urandom_range(0, 4) == 0)
			send_data(CHAR_0, 1'b0);
		while (n > 0) begin
			n--;
			send_data(char_of_digit(digs[n]), !by_space && n == 0);
		end
		if (by_space)
			send_data(SPACE_CHAR, $urandom_range(0, 3) == 0);
	endtask

	// Hold the input until every expected character has arrived, then let the block settle
	task automatic drain_results(input int unsigned extra);
		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DIRECTION)
			dir_mode = data[0];
		else
			radix_reg = data;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic dir, input logic [5:0] base);
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_DIRECTION, {5'($urandom), dir});
		write_reg(CFG_RADIX, base);
	endtask

	// Output side: random ready gaps, plus a long hold-off on request
	initial begin : rx_drive
		int unsigned g;
		@(posedge clk);
		forever begin
			if (rx_hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			g = rx_idle ? $urandom_range(0, 7) : 0;
			if (g != 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid && rx_hold == 0) @(posedge clk);
		end
	end

	// Compare each accepted output request with the oldest expectation
	always @(posedge clk) begin : check_out
		out_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected output: expected none, got char %02h last %b nf %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== want.ch) begin
					errors++;
					$display("%0t: out_char mismatch: expected %02h, got %02h",
						$time, want.ch, m_axis_tdata);
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					$display("%0t: run_last mismatch: expected %b, got %b",
						$time, want.last, m_axis_tlast);
				end
				if (m_axis_tuser !== want.nf) begin
					errors++;
					$display("%0t: not_found mismatch: expected %b, got %b",
						$time, want.nf, m_axis_tuser);
				end
			end
		end
	end

	// Encode corners: longest code, code zero, out-of-range characters, ignored requests
	task automatic test_encode_directed();
		set_mode(1'b0, 6'd2);
		send_write(7'd94, 16'hFFFF);
		send_data(8'd126, 1'b0);
		send_write(7'd0, 16'h0000);
		send_data(SPACE_CHAR, 1'b1);
		send_data(8'd31, 1'b0);
		send_data(8'd127, 1'b0);
		send_data(8'd0, 1'b1);
		send_data(8'd255, 1'b0);
		send_other(CMD_UNUSED);
		send_write(7'd127, 16'h1234);
		send_other(CMD_RESTORE);
		send_data(8'd126, 1'b0);
		set_mode(1'b0, 6'd62);
		send_data(8'd122, 1'b0);
		send_data(8'd126, 1'b1);
	endtask

	// Decode corners: invalid digit, control inside a token, empty token, overflow,
	// duplicate codes, and a token kept open across a direction change
	task automatic test_decode_directed();
		set_mode(1'b1, 6'd16);
		send_data("G", 1'b0);
		send_data("7", 1'b0);
		send_data("E", 1'b0);
		send_data(SPACE_CHAR, 1'b0);
		send_data("4", 1'b0);
		send_item(CMD_WRITE, 8'd0, 7'd127, 16'h0000, 1'b1);
		send_data("1", 1'b1);
		send_data(SPACE_CHAR, 1'b1);
		repeat (4) send_data("F", 1'b0);
		send_data("F", 1'b1);
		send_write(7'd90, 16'h0041);
		send_data("4", 1'b0);
		send_data("1", 1'b0);
		send_data(SPACE_CHAR, 1'b0);
		send_other(CMD_RESTORE);
		send_data("4", 1'b0);
		set_mode(1'b0, 6'd63);
		send_data("A", 1'b0);
		set_mode(1'b1, 6'd16);
		send_data("1", 1'b0);
		send_data(SPACE_CHAR, 1'b0);
	endtask

	// Stall the output long enough to fill the block, then pause the sender
	task automatic test_backpressure();
		set_mode(1'b0, 6'($urandom_range(2, 5)));
		tx_idle = 1'b0;
		rx_hold = 250;
		repeat (12) send_data(8'($urandom_range(32, 126)), 1'b0);
		drain_results(1);
		tx_idle = 1'b1;
		repeat (8) send_data(8'($urandom_range(32, 126)), 1'b0);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom);
			4, 5:    return 16'($urandom_range(0, 100));
			default: return 16'($urandom_range(32, 126));
		endcase
	endfunction

	function automatic logic [6:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return 7'($urandom_range(95, 127));
		return 7'($urandom_range(0, 94));
	endfunction

	// Random phases over direction, radix, idling and request mix
	task automatic test_random_mix();
		int unsigned target, phase_end, p;
		logic [5:0]  base;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0:       base = 6'd2;
				1:       base = 6'd62;
				2:       base = ($urandom_range(0, 1) == 1) ? 6'd63 : 6'($urandom_range(0, 1));
				default: base = 6'($urandom_range(2, 62));
			endcase
			set_mode(1'($urandom), base);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				p = $urandom_range(0, 99);
				if (!dir_mode) begin
					if (p < 75)
						send_data(8'($urandom_range(32, 126)), 1'($urandom));
					else if (p < 83)
						send_data(8'($urandom), 1'($urandom));
					else if (p < 93)
						send_write(pick_index(), pick_code());
					else if (p < 97)
						send_other(CMD_RESTORE);
					else
						send_other(CMD_UNUSED);
				end else begin
					if (p < 70)
						send_token(8'($urandom_range(32, 126)));
					else if (p < 85)
						send_data(8'($urandom), 1'($urandom_range(0, 3) == 0));
					else if (p < 95)
						send_write(pick_index(), ($urandom_range(0, 1) == 1) ?
							code_tbl[$urandom_range(0, 94)] : pick_code());
					else if (p < 98)
						send_other(CMD_RESTORE);
					else
						send_other(CMD_UNUSED);
				end
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		restore_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_encode_directed();
		test_decode_directed();
		test_backpressure();
		test_random_mix();
		drain_results(SETTLE_CYCLES);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
